FILE: hw/rtl/key_value_store_with_lru_order_macros.svh
// ----------------------------------------------------------------------------
// key_value_store_with_lru_order_macros
// Assertion macros used by the key-value store top module.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_STORE_WITH_LRU_ORDER_MACROS_SVH
`define KEY_VALUE_STORE_WITH_LRU_ORDER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define KVS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define KVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define KVS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define KVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/kvs_pkg.sv
// ----------------------------------------------------------------------------
// kvs_pkg
// Types and constants of the key-value store with recency order.
// ----------------------------------------------------------------------------
package kvs_pkg;

  // Store geometry
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned RANK_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DATA_W   = 32;

  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [CNT_W-1:0]  count_t;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INS  = 2'd0,
    REQ_SRCH = 2'd1,
    REQ_DEL  = 2'd2
  } kvs_req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } kvs_status_e;

  // Update applied to the whole cell row
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_SRCH = 2'd2,
    OP_DEL  = 2'd3
  } kvs_op_e;

  // Contents of one cell
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    rank_t             rank;
  } kvs_entry_t;

  // Broadcast command to all cells
  typedef struct packed {
    logic              cmp_en;
    kvs_op_e           op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    rank_t             hit_rank;
  } kvs_cmd_t;

  // Per-cell selects
  typedef struct packed {
    logic target;  // append position for an insert
    logic hit;     // oldest matching entry
    logic shift;   // at or above the hit: take neighbor on delete
  } kvs_sel_t;

endpackage

FILE: hw/rtl/kvs_cell.sv
// ----------------------------------------------------------------------------
// kvs_cell
// One entry of the store: key, data, recency rank and a match flag.
// Cells are kept in arrival order; a delete pulls the upper neighbor down.
// ----------------------------------------------------------------------------
module kvs_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kvs_pkg::kvs_cmd_t   cmd_i,
  input  kvs_pkg::kvs_sel_t   sel_i,
  input  kvs_pkg::kvs_entry_t nbr_i,
  output kvs_pkg::kvs_entry_t entry_o,
  output logic               match_o
);
  import kvs_pkg::*;

  logic              valid_q, valid_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DATA_W-1:0] data_q, data_d;
  rank_t             rank_q, rank_d;
  logic              match_q;
  kvs_entry_t        self_w, src_w;

  assign self_w = '{valid: valid_q, key: key_q, data: data_q, rank: rank_q};
  assign src_w  = sel_i.shift ? nbr_i : self_w;

  // Next state per row command
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    rank_d  = rank_q;
    unique case (cmd_i.op)
      OP_HOLD: begin
      end
      OP_INS: begin
        if (sel_i.target) begin
          valid_d = 1'b1;
          key_d   = cmd_i.key;
          data_d  = cmd_i.data;
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + rank_t'(1);
        end
      end
      OP_SRCH: begin
        if (sel_i.hit) begin
          rank_d = '0;
        end else if (valid_q && (rank_q < cmd_i.hit_rank)) begin
          rank_d = rank_q + rank_t'(1);
        end
      end
      OP_DEL: begin
        valid_d = src_w.valid;
        key_d   = src_w.key;
        data_d  = src_w.data;
        rank_d  = (src_w.valid && (src_w.rank > cmd_i.hit_rank)) ?
                  src_w.rank - rank_t'(1) : src_w.rank;
      end
    endcase
  end

  // Control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.cmp_en) begin
        match_q <= valid_q && (key_q == cmd_i.key);
      end
    end
  end

  // Payload flops
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
    rank_q <= rank_d;
  end

  assign entry_o = self_w;
  assign match_o = match_q;

endmodule

FILE: hw/rtl/key_value_store_with_lru_order.sv
// ----------------------------------------------------------------------------
// key_value_store_with_lru_order
// Key-value store of 64 entries with a recency order, built as a row of cells.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Every request
// goes through these steps in order: the row compares the key in all cells,
// a prefix scan finds the oldest match, its rank and data are picked, the row
// is updated, and the newest/oldest keys are collected. The result is shown
// with done_o high for exactly one cycle, in the same cycle in which busy
// drops; it must be taken then, since it cannot be held off. A new request
// may start in that same cycle.
// ----------------------------------------------------------------------------
`include "key_value_store_with_lru_order_macros.svh"

module key_value_store_with_lru_order (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        req_type_i,
  input  logic signed [kvs_pkg::KEY_W-1:0]  key_i,
  input  logic signed [kvs_pkg::DATA_W-1:0] value_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic signed [kvs_pkg::DATA_W-1:0] found_value_o,
  output logic                              store_empty_o,
  output logic signed [kvs_pkg::KEY_W-1:0]  newest_key_o,
  output logic signed [kvs_pkg::KEY_W-1:0]  oldest_key_o
);
  import kvs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CMP  = 6'b000010,
    S_SCAN = 6'b000100,
    S_PICK = 6'b001000,
    S_UPD  = 6'b010000,
    S_RSP  = 6'b100000
  } kvs_state_e;

  kvs_state_e        state_q, state_d;
  logic [1:0]        req_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] value_q;
  count_t            count_q, count_d;
  logic [CAPACITY-1:0] ge_q, ge_d;
  logic [CAPACITY-1:0] hit_vec;
  logic              found_q;
  rank_t             hit_rank_q, hit_rank_d;
  logic [DATA_W-1:0] hit_data_q, hit_data_d;
  logic [1:0]        stat_q, stat_d;
  logic [DATA_W-1:0] fval_q, fval_d;
  logic [KEY_W-1:0]  newest_q, newest_d, oldest_q, oldest_d;
  logic              empty_q, done_q;
  kvs_op_e           upd_op;
  kvs_cmd_t          cmd_w;
  rank_t             oldest_rank;

  kvs_entry_t          entry_w [CAPACITY];
  kvs_sel_t            sel_w   [CAPACITY];
  logic [CAPACITY-1:0] match_w;
  logic [CAPACITY-1:0] valid_w;

  assign busy = (state_q != S_IDLE);

  // Cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    kvs_entry_t nbr_w;
    if (g == CAPACITY - 1) begin : g_top
      assign nbr_w = '0;
    end else begin : g_mid
      assign nbr_w = entry_w[g+1];
    end
    kvs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd_w),
      .sel_i   (sel_w[g]),
      .nbr_i   (nbr_w),
      .entry_o (entry_w[g]),
      .match_o (match_w[g])
    );
    assign valid_w[g] = entry_w[g].valid;
  end

  // Prefix OR over match flags: log-depth scan
  always_comb begin
    ge_d = match_w;
    for (int l = 0; l < RANK_W; l++) begin
      ge_d = ge_d | (ge_d << (1 << l));
    end
  end

  // First match is the lowest cell, i.e. the oldest-inserted one
  assign hit_vec = ge_q & ~(ge_q << 1);

  // Per-cell selects
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      sel_w[i].target = (count_q == count_t'(i));
      sel_w[i].hit    = hit_vec[i];
      sel_w[i].shift  = ge_q[i];
    end
  end

  // Pick rank and data of the hit cell
  always_comb begin
    hit_rank_d = '0;
    hit_data_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_vec[i]) begin
        hit_rank_d = hit_rank_d | entry_w[i].rank;
        hit_data_d = hit_data_d | entry_w[i].data;
      end
    end
  end

  // Update decision
  always_comb begin
    upd_op  = OP_HOLD;
    stat_d  = ST_OK;
    fval_d  = '0;
    count_d = count_q;
    unique case (req_q)
      REQ_INS: begin
        if (count_q == count_t'(CAPACITY)) begin
          stat_d = ST_FULL;
        end else begin
          upd_op  = OP_INS;
          count_d = count_q + count_t'(1);
        end
      end
      REQ_SRCH: begin
        if (found_q) begin
          upd_op = OP_SRCH;
          fval_d = hit_data_q;
        end else begin
          stat_d = ST_MISS;
        end
      end
      REQ_DEL: begin
        if (found_q) begin
          upd_op  = OP_DEL;
          fval_d  = hit_data_q;
          count_d = count_q - count_t'(1);
        end else begin
          stat_d = ST_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  // Row command
  always_comb begin
    cmd_w.cmp_en   = (state_q == S_CMP);
    cmd_w.op       = (state_q == S_UPD) ? upd_op : OP_HOLD;
    cmd_w.key      = key_q;
    cmd_w.data     = value_q;
    cmd_w.hit_rank = hit_rank_q;
  end

  // Newest and oldest keys of the updated row
  assign oldest_rank = rank_t'(count_q - count_t'(1));
  always_comb begin
    newest_d = '0;
    oldest_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (entry_w[i].valid && (entry_w[i].rank == '0)) begin
        newest_d = newest_d | entry_w[i].key;
      end
      if (entry_w[i].valid && (entry_w[i].rank == oldest_rank)) begin
        oldest_d = oldest_d | entry_w[i].key;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_CMP;
      S_CMP:  state_d = S_SCAN;
      S_SCAN: state_d = S_PICK;
      S_PICK: state_d = S_UPD;
      S_UPD:  state_d = S_RSP;
      S_RSP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_RSP);
      if (state_q == S_UPD) begin
        count_q <= count_d;
      end
      if (state_q == S_PICK) begin
        found_q <= ge_q[CAPACITY-1];
      end
    end
  end

  // Payload flops
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start) begin
      req_q   <= req_type_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (state_q == S_SCAN) begin
      ge_q <= ge_d;
    end
    if (state_q == S_PICK) begin
      hit_rank_q <= hit_rank_d;
      hit_data_q <= hit_data_d;
    end
    if (state_q == S_UPD) begin
      stat_q <= stat_d;
      fval_q <= fval_d;
    end
    if (state_q == S_RSP) begin
      newest_q <= newest_d;
      oldest_q <= oldest_d;
      empty_q  <= (count_q == '0);
    end
  end

  assign done_o        = done_q;
  assign status_o      = stat_q;
  assign found_value_o = fval_q;
  assign store_empty_o = empty_q;
  assign newest_key_o  = newest_q;
  assign oldest_key_o  = oldest_q;

  // Checks
  `KVS_ASSERT_SAME(a_count_match, clk_i, rst_ni, 1'b1, $countones(valid_w) == count_q, "live cells and count disagree")
  `KVS_ASSERT_SAME(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= count_t'(CAPACITY), "count above capacity")
  `KVS_ASSERT_SAME(a_hit_onehot, clk_i, rst_ni, state_q == S_PICK, $onehot0(hit_vec), "more than one hit cell")
  `KVS_ASSERT_NEXT(a_done_after_rsp, clk_i, rst_ni, state_q == S_RSP, done_o && !busy, "result strobe missing")
  `KVS_ASSERT_NEXT(a_full_hold, clk_i, rst_ni, (state_q == S_UPD) && (stat_d == ST_FULL), $stable(count_q), "full insert changed the store")

endmodule
